/* hdl/tcf_pkg.sv */
// tcf_pkg: shared types and codes for the two-class oldest-first FIFO.
// Holds the request and response beat structs and the per-queue control and status structs.
// No dependencies.
package tcf_pkg;

	localparam int unsigned PAYLOAD_W = 16;
	localparam int unsigned STAMP_W   = 6;

	localparam logic [1:0] REQ_ENQ     = 2'd0;
	localparam logic [1:0] REQ_DEQ_ANY = 2'd1;
	localparam logic [1:0] REQ_DEQ_0   = 2'd2;
	localparam logic [1:0] REQ_DEQ_1   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]           req_type;
		logic                 item_class;
		logic [PAYLOAD_W-1:0] in_payload;
	} tcf_req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic                 out_class;
		logic [PAYLOAD_W-1:0] out_payload;
		logic [STAMP_W-1:0]   out_stamp;
	} tcf_rsp_t;

	typedef struct packed {
		logic rd;
		logic push;
		logic pop;
	} tcf_qctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} tcf_qstat_t;

endpackage

/* hdl/tcf_ram.sv */
// tcf_ram: generic simple dual-port RAM, one write port, one read port.
// Read data is registered and holds when no read is issued.
// No dependencies.
module tcf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/tcf_queue.sv */
// tcf_queue: one class FIFO, entry storage in a tcf_ram plus head and count registers.
// Reads the head entry on request, writes at the tail on push, advances on pop.
// Depends on tcf_pkg and tcf_ram.
module tcf_queue #(
	parameter int unsigned DEPTH  = 16,
	parameter int unsigned DATA_W = 22
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tcf_pkg::tcf_qctl_t ctl,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata,
	output tcf_pkg::tcf_qstat_t stat
);
	import tcf_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned SUM_W = CNT_W + 1;

	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] tail_sum;
	logic [PTR_W-1:0] tail;
	logic [PTR_W-1:0] head_nxt;

	always_comb begin
		tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
		if (tail_sum >= SUM_W'(DEPTH)) begin
			tail_sum = tail_sum - SUM_W'(DEPTH);
		end
		tail = tail_sum[PTR_W-1:0];
		head_nxt = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	end

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.push) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.pop) begin
				count_q <= count_q - 1'b1;
				head_q  <= head_nxt;
			end
		end
	end

	tcf_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctl.push),
		.waddr(tail),
		.wdata(wdata),
		.re   (ctl.rd),
		.raddr(head_q),
		.rdata(rdata)
	);

endmodule

/* hdl/two_class_fifo_oldest_first_top.sv */
// Two-class FIFO with oldest-first dequeue: each class keeps its entries and arrival
// stamps in a one-port-read RAM; a 6-bit arrival counter stamps every successful enqueue.
// Each item is handled in steps: the accept cycle reads both queue heads from RAM, the resolve
// state picks the class (class 0 wins ties, age by modular stamp difference), writes or
// pops, and loads the response register. No new beat is taken until the resolve state
// ends; a stalled response holds the resolve state. RAM writes and head reads fall in
// different cycles, so no forwarding is needed. Successful enqueues give no response;
// a full enqueue or an empty dequeue reports its status with payload and stamp zero.
// Depends on tcf_pkg and tcf_queue.
module two_class_fifo_oldest_first_top #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned TAG_WIDTH   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  tcf_pkg::tcf_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output tcf_pkg::tcf_rsp_t rsp
);
	import tcf_pkg::*;

	localparam int unsigned TAG_W  = (TAG_WIDTH < PAYLOAD_W) ? TAG_WIDTH : PAYLOAD_W;
	localparam int unsigned DATA_W = STAMP_W + TAG_W;

	typedef enum logic {
		S_IDLE,
		S_RESOLVE
	} state_t;

	state_t             state_q;
	tcf_req_t           req_s1;
	logic [STAMP_W-1:0] arrival_q;
	logic               rsp_valid_q;
	tcf_rsp_t           rsp_q;

	tcf_qctl_t          ctl0, ctl1;
	tcf_qstat_t         stat0, stat1;
	logic [DATA_W-1:0]  rdata0, rdata1, wdata;

	logic               accept;
	logic               go;
	logic               pick;
	logic [DATA_W-1:0]  pick_data;
	logic [STAMP_W-1:0] diff;
	logic               first_older;
	logic               pick_empty;
	logic               push_ok;
	logic               rsp_load;
	tcf_rsp_t           rsp_d;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign go        = (state_q == S_RESOLVE) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign wdata = {arrival_q, req_s1.in_payload[TAG_W-1:0]};

	always_comb begin
		diff        = rdata0[DATA_W-1 -: STAMP_W] - rdata1[DATA_W-1 -: STAMP_W];
		first_older = (diff == '0) || diff[STAMP_W-1];
		unique case (req_s1.req_type)
			REQ_DEQ_0: pick = 1'b0;
			REQ_DEQ_1: pick = 1'b1;
			REQ_ENQ:   pick = req_s1.item_class;
			default: begin
				if (!stat0.empty && !stat1.empty) begin
					pick = !first_older;
				end else begin
					pick = stat0.empty && !stat1.empty;
				end
			end
		endcase
		pick_data  = pick ? rdata1 : rdata0;
		pick_empty = pick ? stat1.empty : stat0.empty;

		rsp_d.out_class   = pick;
		rsp_d.out_payload = '0;
		rsp_d.out_stamp   = '0;
		push_ok  = 1'b0;
		rsp_load = 1'b1;
		if (req_s1.req_type == REQ_ENQ) begin
			rsp_d.status = ST_FULL;
			if (!(pick ? stat1.full : stat0.full)) begin
				push_ok  = 1'b1;
				rsp_load = 1'b0;
			end
		end else if (pick_empty) begin
			rsp_d.status = ST_EMPTY;
		end else begin
			rsp_d.status      = ST_OK;
			rsp_d.out_payload = PAYLOAD_W'(pick_data[TAG_W-1:0]);
			rsp_d.out_stamp   = pick_data[DATA_W-1 -: STAMP_W];
		end

		ctl0.rd   = accept;
		ctl1.rd   = accept;
		ctl0.push = go && push_ok && !pick;
		ctl1.push = go && push_ok && pick;
		ctl0.pop  = go && (req_s1.req_type != REQ_ENQ) && !pick_empty && !pick;
		ctl1.pop  = go && (req_s1.req_type != REQ_ENQ) && !pick_empty && pick;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			arrival_q   <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (go && rsp_load) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= rsp_d;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RESOLVE;
					end
				end
				S_RESOLVE: begin
					if (go) begin
						state_q <= S_IDLE;
						if (push_ok) begin
							arrival_q <= arrival_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	tcf_queue #(
		.DEPTH (QUEUE_DEPTH),
		.DATA_W(DATA_W)
	) u_q0 (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl0),
		.wdata (wdata),
		.rdata (rdata0),
		.stat  (stat0)
	);

	tcf_queue #(
		.DEPTH (QUEUE_DEPTH),
		.DATA_W(DATA_W)
	) u_q1 (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl1),
		.wdata (wdata),
		.rdata (rdata1),
		.stat  (stat1)
	);

endmodule

/* hdl/tcf_checker.sv */
// tcf_checker: port-level checks for two_class_fifo_oldest_first_top, bound below.
// Watches the request and response beats only.
// Depends on tcf_pkg.
module tcf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input tcf_pkg::tcf_req_t req,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input tcf_pkg::tcf_rsp_t rsp
);
	import tcf_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.out_payload == '0 && rsp.out_stamp == '0)
		else $error("failed request carries payload or stamp");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request side not busy after accepted beat");

	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response appeared without a request in progress");

endmodule

bind two_class_fifo_oldest_first_top tcf_checker u_tcf_checker (.*);

/* bench/tb_two_class_fifo_oldest_first_top.sv */
// Testbench for two_class_fifo_oldest_first_top: directed script, then random requests,
// each reply checked against the script's reply where it gives one, else against a local
// two-queue model with modular stamp ageing. Depends on tcf_pkg and the block's RTL.
module tb_two_class_fifo_oldest_first_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tcf_pkg::*;

	localparam int unsigned DEPTH         = 16;
	localparam int unsigned RANDOM_ITEMS  = 825;
	localparam int unsigned LONG_HOLD     = 300;
	localparam int unsigned QUIET_LIMIT   = 2000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned PRINT_CAP     = 40;

	typedef struct packed {
		logic [PAYLOAD_W-1:0] tag;
		logic [STAMP_W-1:0]   stamp;
	} kennel_entry_t;

	typedef struct packed {
		logic [1:0]           kind;
		logic                 cls;
		logic [PAYLOAD_W-1:0] tag;
		logic [4:0]           reps;
		logic                 known;
		tcf_rsp_t             reply;
	} script_row_t;

	typedef enum {STALL_NONE, STALL_RANDOM, STALL_TOGGLE, STALL_RUNS} stall_mode_t;

	localparam script_row_t SCRIPT [10] = '{
		'{REQ_DEQ_ANY, 1'b0, 16'h0000, 5'd1, 1'b1, '{ST_EMPTY, 1'b0, 16'h0, 6'h0}},
		'{REQ_DEQ_0, 1'b1, 16'hFFFF, 5'd1, 1'b1, '{ST_EMPTY, 1'b0, 16'h0, 6'h0}},
		'{REQ_DEQ_1, 1'b0, 16'h0000, 5'd1, 1'b1, '{ST_EMPTY, 1'b1, 16'h0, 6'h0}},
		'{REQ_ENQ, 1'b1, 16'hFFFF, 5'd1, 1'b0, '0},
		'{REQ_ENQ, 1'b0, 16'h0000, 5'd1, 1'b0, '0},
		'{REQ_DEQ_ANY, 1'b0, 16'h0000, 5'd1, 1'b0, '0},
		'{REQ_ENQ, 1'b1, 16'h8000, 5'd16, 1'b0, '0},
		'{REQ_ENQ, 1'b1, 16'h7FFF, 5'd1, 1'b1, '{ST_FULL, 1'b1, 16'h0, 6'h0}},
		'{REQ_DEQ_ANY, 1'b1, 16'h0000, 5'd1, 1'b0, '0},
		'{REQ_DEQ_1, 1'b0, 16'h0000, 5'd1, 1'b0, '0}
	};

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	tcf_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	tcf_rsp_t rsp;

	logic     beat_known = 1'b0;
	tcf_rsp_t beat_reply = '0;
	bit       hold_off_req = 1'b0;

	kennel_entry_t      dog_q[$];
	kennel_entry_t      cat_q[$];
	logic [STAMP_W-1:0] next_stamp = '0;
	tcf_rsp_t           due_replies[$];
	int unsigned        mismatches = 0;
	int unsigned        quiet_cycles = 0;

	two_class_fifo_oldest_first_top #(
		.QUEUE_DEPTH(DEPTH),
		.TAG_WIDTH(PAYLOAD_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit shelter_predict(input tcf_req_t r, output tcf_rsp_t o);
		kennel_entry_t      e;
		logic [STAMP_W-1:0] age_gap;
		logic               pick;
		o = '0;
		pick = 1'b0;
		case (r.req_type)
		REQ_ENQ: begin
			if ((r.item_class ? cat_q.size() : dog_q.size()) >= DEPTH) begin
				o.status = ST_FULL;
				o.out_class = r.item_class;
				return 1'b1;
			end
			e.tag = r.in_payload;
			e.stamp = next_stamp;
			if (r.item_class)
				cat_q.push_back(e);
			else
				dog_q.push_back(e);
			next_stamp = next_stamp + 1'b1;
			return 1'b0;
		end
		REQ_DEQ_0: pick = 1'b0;
		REQ_DEQ_1: pick = 1'b1;
		default: begin
			if (dog_q.size() != 0 && cat_q.size() != 0) begin
				age_gap = dog_q[0].stamp - cat_q[0].stamp;
				pick = !(age_gap == '0 || age_gap[STAMP_W-1]);
			end else begin
				pick = (dog_q.size() == 0 && cat_q.size() != 0);
			end
		end
		endcase
		o.out_class = pick;
		if ((pick ? cat_q.size() : dog_q.size()) == 0) begin
			o.status = ST_EMPTY;
		end else begin
			e = pick ? cat_q.pop_front() : dog_q.pop_front();
			o.status = ST_OK;
			o.out_payload = e.tag;
			o.out_stamp = e.stamp;
		end
		return 1'b1;
	endfunction

	function automatic tcf_req_t random_request(input int unsigned enq_pct,
			input int unsigned cat_pct);
		tcf_req_t r;
		r.item_class = ($urandom_range(0, 99) < cat_pct);
		case ($urandom_range(0, 7))
		0: r.in_payload = '0;
		1: r.in_payload = '1;
		default: r.in_payload = PAYLOAD_W'($urandom);
		endcase
		if ($urandom_range(0, 99) < enq_pct) begin
			r.req_type = REQ_ENQ;
		end else begin
			case ($urandom_range(0, 2))
			0: r.req_type = REQ_DEQ_ANY;
			1: r.req_type = REQ_DEQ_0;
			default: r.req_type = REQ_DEQ_1;
			endcase
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		if (mismatches < PRINT_CAP)
			$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic offer_beat(input tcf_req_t r, input logic known, input tcf_rsp_t reply);
		@(negedge clk);
		req_valid <= 1'b1;
		req <= r;
		beat_known <= known;
		beat_reply <= reply;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic idle_beat();
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		tcf_rsp_t want;
		tcf_rsp_t guess;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (due_replies.size() == 0) begin
					flag_mismatch($sformatf("reply with none due: %p", rsp));
				end else begin
					want = due_replies.pop_front();
					if (rsp.status !== want.status)
						flag_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
					if (rsp.out_class !== want.out_class)
						flag_mismatch($sformatf("class %0d, want %0d",
							rsp.out_class, want.out_class));
					if (rsp.out_payload !== want.out_payload)
						flag_mismatch($sformatf("payload %h, want %h",
							rsp.out_payload, want.out_payload));
					if (rsp.out_stamp !== want.out_stamp)
						flag_mismatch($sformatf("stamp %0d, want %0d",
							rsp.out_stamp, want.out_stamp));
				end
			end
			if (req_valid && !req_stall) begin
				if (shelter_predict(req, guess))
					due_replies.push_back(beat_known ? beat_reply : guess);
			end
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	stall_mode_t stall_mode = STALL_NONE;
	int unsigned mode_left = 0;
	int unsigned hold_left = 0;
	int unsigned run_left = 0;
	logic        run_level = 1'b0;
	bit          hold_taken = 1'b0;

	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(16, 96);
		end
		mode_left--;
		if (hold_off_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			case (stall_mode)
			STALL_NONE: rsp_stall <= 1'b0;
			STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
			STALL_TOGGLE: rsp_stall <= ~rsp_stall;
			default: begin
				if (run_left == 0) begin
					run_left = $urandom_range(1, 10);
					run_level = ~run_level;
				end
				run_left--;
				rsp_stall <= run_level;
			end
			endcase
		end
	end

	initial begin
		tcf_req_t    beat;
		int unsigned burst_left;
		int unsigned enq_pct;
		int unsigned cat_pct;
		burst_left = 0;
		enq_pct = 50;
		cat_pct = 50;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < $size(SCRIPT); i++) begin
			for (int k = 0; k < SCRIPT[i].reps; k++) begin
				beat.req_type = SCRIPT[i].kind;
				beat.item_class = SCRIPT[i].cls;
				beat.in_payload = SCRIPT[i].tag + PAYLOAD_W'(k);
				offer_beat(beat, SCRIPT[i].known, SCRIPT[i].reply);
			end
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 3))
				0: enq_pct = 90;
				1: enq_pct = 60;
				2: enq_pct = 30;
				default: enq_pct = 10;
				endcase
				case ($urandom_range(0, 2))
				0: cat_pct = 50;
				1: cat_pct = 85;
				default: cat_pct = 15;
				endcase
			end
			if (n == 300)
				hold_off_req = 1'b1;
			if (n == 550) begin
				while (due_replies.size() != 0)
					idle_beat();
				repeat (SETTLE_CYCLES) idle_beat();
			end
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				if (n < 600 || n >= 700)
					repeat ($urandom_range(1, 8)) idle_beat();
			end
			burst_left--;
			offer_beat(random_request(enq_pct, cat_pct), 1'b0, '0);
		end

		idle_beat();
		while (due_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* files.f */
hdl/tcf_pkg.sv
hdl/tcf_ram.sv
hdl/tcf_queue.sv
hdl/two_class_fifo_oldest_first_top.sv
hdl/tcf_checker.sv
bench/tb_two_class_fifo_oldest_first_top.sv
